/* src/wfpd_pkg.sv */
package wfpd_pkg;

    // Field widths
    localparam int DIST_W = 12;
    localparam int GAIN_W = 10;
    localparam int PWM_W  = 13;
    localparam int DUTY_W = 14;
    localparam int ERR_W  = 13;   // setpoint - right lies in [-2048, 4095]
    localparam int PERR_W = 14;   // stored previous error
    localparam int DIFF_W = 15;   // err - prev_error
    localparam int ACC_W  = 28;   // wide enough for the full right-duty sum
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUN_ENABLE       = 3'd0,
        CFG_GAIN_P           = 3'd1,
        CFG_GAIN_I           = 3'd2,
        CFG_GAIN_D           = 3'd3,
        CFG_DESIRED_DISTANCE = 3'd4,
        CFG_PWM_NOMINAL      = 3'd5,
        CFG_PWM_SWING        = 3'd6
    } cfg_idx_t;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_P_RST           = 10'd4;
    localparam logic [GAIN_W-1:0] GAIN_I_RST           = 10'd0;
    localparam logic [GAIN_W-1:0] GAIN_D_RST           = 10'd100;
    localparam logic [DIST_W-1:0] DESIRED_DISTANCE_RST = 12'd250;
    localparam logic [PWM_W-1:0]  PWM_NOMINAL_RST      = 13'd7500;
    localparam logic [PWM_W-1:0]  PWM_SWING_RST        = 13'd1000;

    // Turn override thresholds, mm
    localparam logic [DIST_W-1:0] TURN_NEAR   = 12'd250;
    localparam logic [DIST_W-1:0] TURN_SLIGHT = 12'd300;
    localparam logic [DIST_W-1:0] FAR_CENTER  = 12'd400;
    localparam logic [DIST_W-1:0] FAR_MARGIN  = 12'd50;
    localparam logic [DIST_W-1:0] FAR_RIGHT   = FAR_CENTER + FAR_MARGIN;
    localparam logic [DIST_W-1:0] HARD_LEFT   = 12'd275;

endpackage

/* src/wall_follow_pd_steering.sv */
// Pipeline: 2 register stages, input register then result register; the PD math sits in
// a single stage between them. Throughput: one transaction per cycle unless out_ready
// stalls; prev_error updates as each item moves into the result register.
// Reset (rst_n low, asynchronous): pipeline empty, prev_error = 0, configuration
// registers back to run_enable=0, gains 4/0/100, desired 250, nominal 7500, swing 1000.
module wall_follow_pd_steering (
    input  logic                               clk,
    input  logic                               rst_n,

    // configuration write port
    input  logic                               cfg_we,
    input  logic [wfpd_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [wfpd_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // sensor triple in
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [wfpd_pkg::DIST_W-1:0]        left_dist,
    input  logic [wfpd_pkg::DIST_W-1:0]        center_dist,
    input  logic [wfpd_pkg::DIST_W-1:0]        right_dist,

    // duty pair out
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [wfpd_pkg::DUTY_W-1:0]        right_duty,
    output logic [wfpd_pkg::DUTY_W-1:0]        left_duty
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                              run_enable_reg;
    logic [wfpd_pkg::GAIN_W-1:0]       gain_p_reg;
    logic [wfpd_pkg::GAIN_W-1:0]       gain_i_reg;
    logic [wfpd_pkg::GAIN_W-1:0]       gain_d_reg;
    logic [wfpd_pkg::DIST_W-1:0]       desired_distance_reg;
    logic [wfpd_pkg::PWM_W-1:0]        pwm_nominal_reg;
    logic [wfpd_pkg::PWM_W-1:0]        pwm_swing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_enable_reg       <= 1'b0;
            gain_p_reg           <= wfpd_pkg::GAIN_P_RST;
            gain_i_reg           <= wfpd_pkg::GAIN_I_RST;
            gain_d_reg           <= wfpd_pkg::GAIN_D_RST;
            desired_distance_reg <= wfpd_pkg::DESIRED_DISTANCE_RST;
            pwm_nominal_reg      <= wfpd_pkg::PWM_NOMINAL_RST;
            pwm_swing_reg        <= wfpd_pkg::PWM_SWING_RST;
        end
        else if (cfg_we)
        begin
            // out-of-map indexes fall through to default and are dropped
            case (wfpd_pkg::cfg_idx_t'(cfg_addr))
                wfpd_pkg::CFG_RUN_ENABLE:       run_enable_reg       <= cfg_wdata[0];
                wfpd_pkg::CFG_GAIN_P:           gain_p_reg           <= cfg_wdata[wfpd_pkg::GAIN_W-1:0];
                wfpd_pkg::CFG_GAIN_I:           gain_i_reg           <= cfg_wdata[wfpd_pkg::GAIN_W-1:0];
                wfpd_pkg::CFG_GAIN_D:           gain_d_reg           <= cfg_wdata[wfpd_pkg::GAIN_W-1:0];
                wfpd_pkg::CFG_DESIRED_DISTANCE: desired_distance_reg <= cfg_wdata[wfpd_pkg::DIST_W-1:0];
                wfpd_pkg::CFG_PWM_NOMINAL:      pwm_nominal_reg      <= cfg_wdata[wfpd_pkg::PWM_W-1:0];
                wfpd_pkg::CFG_PWM_SWING:        pwm_swing_reg        <= cfg_wdata[wfpd_pkg::PWM_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register. A stopped item (run_enable low at accept)
    // travels with s1_run_reg = 0 and is dropped without a result.
    // ------------------------------------------------------------------
    logic                          s1_valid_reg;
    logic                          s1_run_reg;
    logic [wfpd_pkg::DIST_W-1:0]   s1_left_reg;
    logic [wfpd_pkg::DIST_W-1:0]   s1_center_reg;
    logic [wfpd_pkg::DIST_W-1:0]   s1_right_reg;

    logic                          out_valid_reg;
    logic [wfpd_pkg::DUTY_W-1:0]   right_duty_reg;
    logic [wfpd_pkg::DUTY_W-1:0]   left_duty_reg;
    logic [wfpd_pkg::PERR_W-1:0]   prev_error_reg;

    logic out_free;
    logic s1_fire;
    logic s1_load;
    logic in_fire;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && (!s1_run_reg || out_free);
    assign s1_load  = s1_fire && s1_run_reg;
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_run_reg   <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
            s1_run_reg   <= run_enable_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_left_reg   <= left_dist;
            s1_center_reg <= center_dist;
            s1_right_reg  <= right_dist;
        end
    end

    // ------------------------------------------------------------------
    // PD math
    // ------------------------------------------------------------------
    logic [wfpd_pkg::DIST_W-1:0]         setpoint;
    logic signed [wfpd_pkg::ERR_W-1:0]   err;
    logic signed [wfpd_pkg::DIFF_W-1:0]  err_diff;
    logic signed [wfpd_pkg::GAIN_W:0]    gp_s;
    logic signed [wfpd_pkg::GAIN_W:0]    gi_s;
    logic signed [wfpd_pkg::GAIN_W:0]    gd_s;
    logic signed [wfpd_pkg::GAIN_W+wfpd_pkg::ERR_W:0]   p_term;
    logic signed [wfpd_pkg::GAIN_W+wfpd_pkg::ERR_W:0]   i_term;
    logic signed [wfpd_pkg::GAIN_W+wfpd_pkg::DIFF_W:0]  d_term;
    logic signed [wfpd_pkg::ACC_W-1:0]   nom_s;
    logic signed [wfpd_pkg::ACC_W-1:0]   hi_s;
    logic signed [wfpd_pkg::ACC_W-1:0]   lo_s;
    logic signed [wfpd_pkg::ACC_W-1:0]   lo_raw;
    logic signed [wfpd_pkg::ACC_W-1:0]   r_sum;
    logic signed [wfpd_pkg::ACC_W-1:0]   l_sum;
    logic signed [wfpd_pkg::ACC_W-1:0]   r_clamp;
    logic signed [wfpd_pkg::ACC_W-1:0]   l_clamp;
    logic [wfpd_pkg::DUTY_W-1:0]         nom_d;
    logic [wfpd_pkg::DUTY_W-1:0]         nom_half;
    logic [wfpd_pkg::DUTY_W-1:0]         hi_d;
    logic [wfpd_pkg::DUTY_W-1:0]         right_duty_next;
    logic [wfpd_pkg::DUTY_W-1:0]         left_duty_next;

    always_comb
    begin
        // setpoint tracks half the right reading when far from the wall
        if (s1_right_reg > desired_distance_reg)
            setpoint = s1_right_reg >> 1;
        else
            setpoint = desired_distance_reg;

        err      = $signed({1'b0, setpoint}) - $signed({1'b0, s1_right_reg});
        err_diff = wfpd_pkg::DIFF_W'(err) - wfpd_pkg::DIFF_W'($signed(prev_error_reg));

        gp_s = $signed({1'b0, gain_p_reg});
        gi_s = $signed({1'b0, gain_i_reg});
        gd_s = $signed({1'b0, gain_d_reg});

        p_term = gp_s * err;
        i_term = gi_s * err;
        d_term = gd_s * err_diff;

        nom_s  = wfpd_pkg::ACC_W'($signed({1'b0, pwm_nominal_reg}));
        hi_s   = nom_s + wfpd_pkg::ACC_W'($signed({1'b0, pwm_swing_reg}));
        lo_raw = nom_s - wfpd_pkg::ACC_W'($signed({1'b0, pwm_swing_reg}));
        lo_s   = (lo_raw < 0) ? '0 : lo_raw;

        r_sum = nom_s + wfpd_pkg::ACC_W'(p_term) + wfpd_pkg::ACC_W'(d_term)
              + wfpd_pkg::ACC_W'(i_term);
        l_sum = nom_s - wfpd_pkg::ACC_W'(p_term);

        r_clamp = r_sum;
        if (r_clamp < lo_s) r_clamp = lo_s;
        if (r_clamp > hi_s) r_clamp = hi_s;
        l_clamp = l_sum;
        if (l_clamp < lo_s) l_clamp = lo_s;
        if (l_clamp > hi_s) l_clamp = hi_s;

        nom_d    = wfpd_pkg::DUTY_W'(pwm_nominal_reg);
        nom_half = wfpd_pkg::DUTY_W'(pwm_nominal_reg >> 1);
        hi_d     = hi_s[wfpd_pkg::DUTY_W-1:0];

        right_duty_next = r_clamp[wfpd_pkg::DUTY_W-1:0];
        left_duty_next  = l_clamp[wfpd_pkg::DUTY_W-1:0];

        // turn overrides, later ones win
        if (s1_center_reg < wfpd_pkg::TURN_NEAR)
        begin
            left_duty_next  = '0;
            right_duty_next = nom_d;
        end
        else if (s1_center_reg < wfpd_pkg::TURN_SLIGHT)
        begin
            left_duty_next  = nom_half;
            right_duty_next = nom_d;
        end
        if (s1_right_reg > wfpd_pkg::FAR_RIGHT && s1_center_reg > wfpd_pkg::FAR_CENTER)
        begin
            left_duty_next  = nom_d;
            right_duty_next = nom_half;
        end
        if (s1_left_reg < wfpd_pkg::HARD_LEFT)
        begin
            left_duty_next  = '0;
            right_duty_next = hi_d;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: result register and error history
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            prev_error_reg <= '0;
        end
        else
        begin
            if (s1_load)
            begin
                out_valid_reg  <= 1'b1;
                prev_error_reg <= wfpd_pkg::PERR_W'(err);
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            right_duty_reg <= right_duty_next;
            left_duty_reg  <= left_duty_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign right_duty = right_duty_reg;
    assign left_duty  = left_duty_reg;

`ifndef SYNTH
    // a stopped item must leave the error history untouched
    a_stop_holds_err: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_run_reg) |=> $stable(prev_error_reg))
        else $error("prev_error changed on a stopped transaction");

    // a running item lands in the result register with its error recorded
    a_load_records: assert property (@(posedge clk) disable iff (!rst_n)
        s1_load |=> (out_valid_reg && prev_error_reg == $past(wfpd_pkg::PERR_W'(err))))
        else $error("result load did not update output or error history");

    // a running item blocked by a full result register stays in stage 1
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_run_reg && !out_free) |=>
        (s1_valid_reg && $stable(s1_right_reg) && $stable(s1_run_reg)))
        else $error("stalled transaction lost from input register");
`endif

endmodule
